// ----- sv/pcr_pkg.sv -----
// Shared types, character codes and reply formatting for the pendant command responder.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package pcr_pkg;

    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_A      = 8'h41;

    // Request kinds carried in the input tuser.
    localparam logic REQ_RX_BYTE  = 1'b0;
    localparam logic REQ_TX_READY = 1'b1;

    // Reply lengths; the position counter only has to reach the longer one.
    localparam int          POS_W   = 4;
    localparam logic [3:0]  LEN_R   = 4'd5;
    localparam logic [3:0]  LEN_S   = 4'd11;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  rx_byte;
        logic        framing_error;
        logic [15:0] encoder_delta;
        logic [2:0]  axis_select;
        logic [2:0]  step_select;
        logic        estop_pressed;
    } t_item;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       encoder_reset;
        logic       busy_res;
    } t_result;

    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = CH_ZERO + {4'd0, v};
        end else begin
            r = CH_A + {4'd0, v} - 8'd10;
        end
        return r;
    endfunction

    // Byte at a given position of the reply that is currently queued.
    function automatic logic [7:0] reply_byte(
        input logic             is_s,
        input logic [POS_W-1:0] pos,
        input logic [15:0]      delta,
        input logic [6:0]       sw
    );
        logic [7:0] r;
        r = 8'd0;
        if (!is_s) begin
            case (pos)
                4'd0:    r = CH_LBRACK;
                4'd1:    r = CH_R;
                4'd2:    r = CH_RBRACK;
                4'd3:    r = CH_CR;
                4'd4:    r = CH_LF;
                default: r = 8'd0;
            endcase
        end else begin
            case (pos)
                4'd0:    r = CH_LBRACK;
                4'd1:    r = CH_S;
                4'd2:    r = hex_digit(delta[15:12]);
                4'd3:    r = hex_digit(delta[11:8]);
                4'd4:    r = hex_digit(delta[7:4]);
                4'd5:    r = hex_digit(delta[3:0]);
                4'd6:    r = hex_digit({1'b0, sw[6:4]});
                4'd7:    r = hex_digit(sw[3:0]);
                4'd8:    r = CH_RBRACK;
                4'd9:    r = CH_CR;
                4'd10:   r = CH_LF;
                default: r = 8'd0;
            endcase
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/pcr_in_reg.sv -----
// Input register stage of the pendant command responder.
// Depends on pcr_pkg for the item type.
`timescale 1ns / 1ps
`default_nettype none

module pcr_in_reg (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire pcr_pkg::t_item i_item,
    input  wire                 i_advance,
    output logic                o_valid,
    output pcr_pkg::t_item      o_item
);

    logic           r_valid;
    pcr_pkg::t_item r_item;

    // The stage can reload in the same cycle that its item moves on.
    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

// ----- sv/pcr_core.sv -----
// Command decode, reply state and reply byte selection of the pendant command responder.
// Depends on pcr_pkg for types, character codes and the reply formatter.
`timescale 1ns / 1ps
`default_nettype none

module pcr_core (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_advance,
    input  wire pcr_pkg::t_item i_item,
    output pcr_pkg::t_result    o_result
);

    logic                     r_responding;
    logic [pcr_pkg::POS_W-1:0] r_pos;
    logic                     r_is_s;
    logic [15:0]              r_delta;
    logic [6:0]               r_sw;

    logic                     n_responding;
    logic [pcr_pkg::POS_W-1:0] n_pos;
    logic                     n_is_s;
    logic                     capture;
    logic [pcr_pkg::POS_W-1:0] cur_len;

    assign cur_len = r_is_s ? pcr_pkg::LEN_S : pcr_pkg::LEN_R;

    always_comb begin
        n_responding = r_responding;
        n_pos        = r_pos;
        n_is_s       = r_is_s;
        capture      = 1'b0;
        o_result     = '0;
        if (i_item.req_type == pcr_pkg::REQ_RX_BYTE) begin
            if (!r_responding && !i_item.framing_error) begin
                if (i_item.rx_byte == pcr_pkg::CH_R) begin
                    o_result.encoder_reset = 1'b1;
                    n_is_s       = 1'b0;
                    n_pos        = '0;
                    n_responding = 1'b1;
                end else if (i_item.rx_byte == pcr_pkg::CH_S) begin
                    capture      = 1'b1;
                    n_is_s       = 1'b1;
                    n_pos        = '0;
                    n_responding = 1'b1;
                end
            end
        end else if (r_responding) begin
            if (r_pos < cur_len) begin
                o_result.tx_valid = 1'b1;
                o_result.tx_byte  = pcr_pkg::reply_byte(r_is_s, r_pos, r_delta, r_sw);
                n_pos             = r_pos + 1'b1;
            end else begin
                n_responding = 1'b0;
            end
        end
        o_result.busy_res = n_responding;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_responding <= 1'b0;
            r_pos        <= '0;
            r_is_s       <= 1'b0;
        end else if (i_advance) begin
            r_responding <= n_responding;
            r_pos        <= n_pos;
            r_is_s       <= n_is_s;
        end
    end

    // The reply text is rebuilt from the fields captured with the 'S' command.
    always_ff @(posedge i_clk) begin
        if (i_advance && capture) begin
            r_delta <= i_item.encoder_delta;
            r_sw    <= {i_item.estop_pressed, i_item.step_select, i_item.axis_select};
        end
    end

endmodule

`default_nettype wire

// ----- sv/pcr_out_reg.sv -----
// Result register of the pendant command responder; holds one item for the output side.
// Depends on pcr_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module pcr_out_reg (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_ready,
    input  wire pcr_pkg::t_result i_result,
    output logic                  o_valid,
    input  wire                   i_ready,
    output pcr_pkg::t_result      o_result
);

    logic             r_valid;
    pcr_pkg::t_result r_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

// ----- sv/pendant_command_responder.sv -----
// Top level of the pendant command responder: input register, command core, result register.
// Depends on pcr_pkg, pcr_in_reg, pcr_core and pcr_out_reg.
//
//  Channel   Direction  Ports            Content
//  s_axis    in         tdata, tuser     received byte or transmit-ready request
//  m_axis    out        tdata, tuser     reply byte, encoder-reset strobe, busy flag
//
// Every input item gives exactly one result item. An item is held in the input register and
// moves into the result register when that register can take it, so one item can be taken
// every cycle while m_axis does not stall. While a finished item waits in the result register the
// input register can still take one more item; after that a stall on m_axis holds
// s_axis_tready low.
// Reset (synchronous, active low) empties both registers and returns the core to idle.
`timescale 1ns / 1ps
`default_nettype none

module pendant_command_responder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] rx_byte, [23:8] encoder_delta, [26:24] axis_select, [29:27] step_select,
    // [30] estop_pressed, [31] zero
    input  wire  [31:0] s_axis_tdata,
    // [0] req_type, [1] framing_error
    input  wire  [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [7:0] tx_byte, [8] encoder_reset, [9] busy_res, [15:10] zero
    output logic [15:0] m_axis_tdata,
    // [0] tx_valid
    output logic        m_axis_tuser
);

    pcr_pkg::t_item   in_item;
    pcr_pkg::t_item   stage_item;
    pcr_pkg::t_result core_result;
    pcr_pkg::t_result out_result;
    logic             stage_valid;
    logic             out_ready;
    logic             advance;

    always_comb begin
        in_item.req_type      = s_axis_tuser[0];
        in_item.framing_error = s_axis_tuser[1];
        in_item.rx_byte       = s_axis_tdata[7:0];
        in_item.encoder_delta = s_axis_tdata[23:8];
        in_item.axis_select   = s_axis_tdata[26:24];
        in_item.step_select   = s_axis_tdata[29:27];
        in_item.estop_pressed = s_axis_tdata[30];
    end

    assign advance = stage_valid && out_ready;

    pcr_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (stage_valid),
        .o_item    (stage_item)
    );

    pcr_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (stage_item),
        .o_result  (core_result)
    );

    pcr_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (stage_valid),
        .o_ready  (out_ready),
        .i_result (core_result),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_result)
    );

    assign m_axis_tdata = {6'd0, out_result.busy_res, out_result.encoder_reset,
                           out_result.tx_byte};
    assign m_axis_tuser = out_result.tx_valid;

endmodule

`default_nettype wire
